/* src/smx_pkg.sv */
// shared opcodes, status codes and control types of the stack machine execute unit
package smx_pkg;

    localparam int DATA_W = 64;
    localparam int LEN_W  = 17;

    localparam logic [3:0] OP_PRINT = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_ADD   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_EQ    = 4'd4;
    localparam logic [3:0] OP_NEQ   = 4'd5;
    localparam logic [3:0] OP_DUP   = 4'd6;
    localparam logic [3:0] OP_EXIT  = 4'd7;
    localparam logic [3:0] OP_POP   = 4'd8;
    localparam logic [3:0] OP_WRITE = 4'd9;
    localparam logic [3:0] OP_WCHAR = 4'd10;
    localparam logic [3:0] OP_JMP   = 4'd11;
    localparam logic [3:0] OP_JMPZ  = 4'd12;

    localparam logic [2:0] ST_RUN       = 3'd0;
    localparam logic [2:0] ST_HALT      = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_DIVZERO   = 3'd4;
    localparam logic [2:0] ST_PCRANGE   = 3'd5;

    localparam logic [1:0] EMIT_NONE  = 2'd0;
    localparam logic [1:0] EMIT_PRINT = 2'd1;
    localparam logic [1:0] EMIT_NUM   = 2'd2;
    localparam logic [1:0] EMIT_CHAR  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic start_div;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic need_div;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

/* src/smx_div.sv */
// iterative signed 64-bit divider, one quotient bit per cycle, truncating toward zero
module smx_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [smx_pkg::DATA_W-1:0] num,
    input  logic [smx_pkg::DATA_W-1:0] den,
    output logic                      done,
    output logic [smx_pkg::DATA_W-1:0] quotient
);
    import smx_pkg::*;

    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W:0]   rem_reg, rem_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   rem_sh;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
        if (start)
        begin
            quo_next  = num[DATA_W-1] ? (~num + 1'b1) : num;
            den_next  = den[DATA_W-1] ? (~den + 1'b1) : den;
            neg_next  = num[DATA_W-1] ^ den[DATA_W-1];
            rem_next  = '0;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
endmodule

/* src/smx_ctrl.sv */
// sequencer: accept, execute, optional divide, commit
module smx_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  smx_pkg::stat_t stat,
    output smx_pkg::cmd_t  cmd,
    output logic           in_ready
);
    import smx_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (stat.in_valid) state_next = S_EXEC;
            S_EXEC:
            begin
                if (stat.need_div)
                    state_next = S_DIV;
                else if (stat.out_free)
                    state_next = S_IDLE;
            end
            S_DIV:  if (stat.div_done) state_next = S_FIN;
            S_FIN:  if (stat.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = stat.in_valid;
            end
            S_EXEC:
            begin
                cmd.start_div = stat.need_div;
                cmd.commit    = !stat.need_div && stat.out_free;
            end
            S_DIV: ;
            S_FIN: cmd.commit = stat.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

/* src/smx_datapath.sv */
// operand stack, pc, instruction execution and result register
module smx_datapath #(
    parameter int STACK_DEPTH = 64,
    parameter int PC_WIDTH    = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  smx_pkg::cmd_t               cmd,
    output smx_pkg::stat_t              stat,
    input  logic                        in_valid,
    input  logic [3:0]                  operation,
    input  logic [smx_pkg::DATA_W-1:0]  argument,
    input  logic                        cfg_valid,
    input  logic [smx_pkg::LEN_W-1:0]   cfg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [PC_WIDTH-1:0]         next_pc,
    output logic [2:0]                  status,
    output logic [1:0]                  emit_kind,
    output logic [smx_pkg::DATA_W-1:0]  emit_value,
    output logic [smx_pkg::DATA_W-1:0]  top_value
);
    import smx_pkg::*;

    localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int CMPW = ((PC_WIDTH > LEN_W) ? PC_WIDTH : LEN_W) + 1;

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    logic [3:0]          op_reg;
    logic [DATA_W-1:0]   arg_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [DATA_W-1:0]   top_reg, top_next;
    logic [PC_WIDTH-1:0] pc_reg, pc_next;
    logic                halted_reg;
    logic [2:0]          stop_reg;
    logic [LEN_W-1:0]    plen_reg;
    logic                out_valid_reg;
    logic [PC_WIDTH-1:0] out_pc_reg;
    logic [2:0]          out_status_reg, st;
    logic [1:0]          out_kind_reg, kind;
    logic [DATA_W-1:0]   out_emit_reg, emit;
    logic [DATA_W-1:0]   out_top_reg;

    logic              wr_en;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] a, b, r, quotient;
    logic              pc_ok, target_ok, n_ge1, n_ge2, full, running;
    logic              div_done;

    smx_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .num      (rdata_reg),
        .den      (top_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign a         = top_reg;
    assign b         = rdata_reg;
    assign n_ge1     = count_reg != '0;
    assign n_ge2     = count_reg > CW'(1);
    assign full      = count_reg == CW'(STACK_DEPTH);
    assign pc_ok     = CMPW'(pc_reg) < CMPW'(plen_reg);
    assign target_ok = !arg_reg[DATA_W-1] && (arg_reg[DATA_W-2:0] < (DATA_W-1)'(plen_reg));
    assign running   = !halted_reg && pc_ok;

    assign stat.in_valid = in_valid;
    assign stat.need_div = running && op_reg == OP_DIV && n_ge2 && a != '0;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (op_reg)
            OP_ADD:  r = a + b;
            OP_DIV:  r = quotient;
            OP_EQ:   r = DATA_W'(a == b);
            default: r = DATA_W'(a != b);
        endcase
    end

    always_comb
    begin
        st         = ST_RUN;
        kind       = EMIT_NONE;
        emit       = '0;
        pc_next    = pc_reg + 1'b1;
        count_next = count_reg;
        top_next   = top_reg;
        wr_en      = 1'b0;
        wr_data    = top_reg;
        if (halted_reg)
        begin
            st      = stop_reg;
            pc_next = pc_reg;
        end
        else if (!pc_ok)
            st = ST_PCRANGE;
        else
        begin
            unique case (op_reg)
                OP_PRINT, OP_WRITE, OP_WCHAR:
                begin
                    if (!n_ge1)
                        st = ST_UNDERFLOW;
                    else
                    begin
                        kind = (op_reg == OP_PRINT) ? EMIT_PRINT :
                               (op_reg == OP_WRITE) ? EMIT_NUM : EMIT_CHAR;
                        emit = (op_reg == OP_WCHAR) ? {{(DATA_W-8){1'b0}}, a[7:0]} : a;
                    end
                end
                OP_LOAD, OP_DUP:
                begin
                    if (op_reg == OP_DUP && !n_ge1)
                        st = ST_UNDERFLOW;
                    else if (full)
                        st = ST_OVERFLOW;
                    else
                    begin
                        wr_en      = n_ge1;
                        top_next   = (op_reg == OP_LOAD) ? arg_reg : a;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_ADD, OP_DIV, OP_EQ, OP_NEQ:
                begin
                    if (!n_ge2)
                        st = ST_UNDERFLOW;
                    else if (op_reg == OP_DIV && a == '0)
                        st = ST_DIVZERO;
                    else
                    begin
                        top_next   = r;
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_EXIT: st = n_ge1 ? ST_HALT : ST_UNDERFLOW;
                OP_POP:
                begin
                    if (!n_ge1)
                        st = ST_UNDERFLOW;
                    else
                    begin
                        top_next   = b;
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_JMP:
                begin
                    if (!target_ok)
                        st = ST_PCRANGE;
                    else
                        pc_next = arg_reg[PC_WIDTH-1:0];
                end
                OP_JMPZ:
                begin
                    if (!n_ge1)
                        st = ST_UNDERFLOW;
                    else if (a == '0 && !target_ok)
                        st = ST_PCRANGE;
                    else
                    begin
                        if (a == '0)
                            pc_next = arg_reg[PC_WIDTH-1:0];
                        top_next   = b;
                        count_next = count_reg - 1'b1;
                    end
                end
                default: ;
            endcase
            if (st != ST_RUN && st != ST_HALT)
            begin
                pc_next = pc_reg;
                kind    = EMIT_NONE;
                emit    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pc_reg        <= '0;
            halted_reg    <= 1'b0;
            stop_reg      <= ST_RUN;
            plen_reg      <= LEN_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                plen_reg <= cfg_data;
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.commit)
            begin
                count_reg     <= count_next;
                pc_reg        <= pc_next;
                // a fetch outside the program reports but does not stop the machine
                if (st != ST_RUN && pc_ok)
                begin
                    halted_reg <= 1'b1;
                    stop_reg   <= st;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= operation;
            arg_reg <= argument;
            if (n_ge2)
                rdata_reg <= mem[AW'(count_reg - CW'(2))];
        end
        if (cmd.commit)
        begin
            top_reg        <= top_next;
            out_pc_reg     <= pc_next;
            out_status_reg <= st;
            out_kind_reg   <= kind;
            out_emit_reg   <= emit;
            out_top_reg    <= (count_next == '0) ? '0 : top_next;
            if (wr_en)
                mem[AW'(count_reg - CW'(1))] <= wr_data;
        end
    end

    assign out_valid  = out_valid_reg;
    assign next_pc    = out_pc_reg;
    assign status     = out_status_reg;
    assign emit_kind  = out_kind_reg;
    assign emit_value = out_emit_reg;
    assign top_value  = out_top_reg;
endmodule

/* src/stack_machine_execute_unit_top.sv */
// stack machine execute unit: one instruction in, one result out per transfer
// the result is registered on commit in the execute state, or in the finish state after a divide
// no new instruction is taken until the last one commits; a divide yields one quotient bit a cycle
// a result not yet taken holds the commit, and so the next input, until it is taken
// reset clears pc, stack count, halt state; program length resets to 1
module stack_machine_execute_unit_top #(
    parameter int STACK_DEPTH = 64,
    parameter int PC_WIDTH    = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [3:0]                  operation,
    input  logic [smx_pkg::DATA_W-1:0]  argument,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [smx_pkg::LEN_W-1:0]   cfg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [PC_WIDTH-1:0]         next_pc,
    output logic [2:0]                  status,
    output logic [1:0]                  emit_kind,
    output logic [smx_pkg::DATA_W-1:0]  emit_value,
    output logic [smx_pkg::DATA_W-1:0]  top_value
);
    import smx_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    smx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    smx_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .PC_WIDTH    (PC_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_valid   (in_valid),
        .operation  (operation),
        .argument   (argument),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .next_pc    (next_pc),
        .status     (status),
        .emit_kind  (emit_kind),
        .emit_value (emit_value),
        .top_value  (top_value)
    );
endmodule
